FILE: design/ppmhp_pkg.sv
// Shared types, character codes and defaults for the PPM header parser.
package ppmhp_pkg;

  localparam int MAX_TOKEN_CHARS_DEF = 5;
  localparam int QUEUE_DEPTH_DEF     = 2;

  localparam int VALUE_W = 17;
  localparam int MAXV_W  = 16;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_SIX   = 8'd54;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_BAD_WIDTH  = 3'd2,
    ST_BAD_HEIGHT = 3'd3,
    ST_BAD_MAXVAL = 3'd4,
    ST_TRUNCATED  = 3'd5
  } status_t;

  // One input byte together with its character class.
  typedef struct packed {
    logic [7:0] data;
    logic       is_final;
    logic       is_sep;
    logic       is_hash;
    logic       is_lf;
    logic       is_digit;
  } item_t;

  // One header report.
  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] width;
    logic [VALUE_W-1:0] height;
    logic [MAXV_W-1:0]  max_value;
    logic [7:0]         first_data_byte;
  } result_t;

endpackage

FILE: design/ppmhp_fifo.sv
// Small synchronous queue of registers with full and empty flags.
module ppmhp_fifo
  import ppmhp_pkg::*;
#(
  parameter int  DEPTH = QUEUE_DEPTH_DEF,
  parameter type T     = item_t
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: design/ppmhp_front.sv
// Front end: classifies each incoming byte before it is queued.
module ppmhp_front
  import ppmhp_pkg::*;
(
  input  logic [7:0] data_byte,
  input  logic       is_final,
  output item_t      item
);

  always_comb begin
    item.data     = data_byte;
    item.is_final = is_final;
    item.is_hash  = (data_byte == CH_HASH);
    item.is_lf    = (data_byte == CH_LF);
    item.is_sep   = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                    (data_byte == CH_CR) || (data_byte == CH_LF) ||
                    (data_byte == CH_HASH);
    item.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  end

endmodule

FILE: design/ppmhp_back.sv
// Back end: header parse state machine, one classified byte per cycle while the result queue has room.
module ppmhp_back
  import ppmhp_pkg::*;
#(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  localparam int LW = $clog2(MAX_TOKEN_CHARS + 1);

  typedef enum logic [2:0] {
    PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_DATA, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               in_comment_r, in_comment_nxt;
  logic               in_sep_r, in_sep_nxt;
  logic [LW-1:0]      tok_len_r, tok_len_nxt;
  logic [VALUE_W-1:0] tok_val_r, tok_val_nxt;
  logic               tok_bad_r, tok_bad_nxt;
  logic [VALUE_W-1:0] saved_w_r, saved_w_nxt;
  logic [VALUE_W-1:0] saved_h_r, saved_h_nxt;
  logic [VALUE_W+3:0] mac;
  logic               step;

  // Decimal accumulate: value * 10 + digit, wide enough to detect overflow.
  assign mac = {tok_val_r, 3'b000} + {2'b00, tok_val_r, 1'b0} +
               {{(VALUE_W){1'b0}}, item.data[3:0]};

  assign step     = item_valid && !res_full;
  assign item_pop = step;

  always_comb begin
    logic active;
    logic tok_phase;
    logic ok;
    active         = 1'b0;
    tok_phase      = 1'b0;
    ok             = 1'b0;
    phase_nxt      = phase_r;
    in_comment_nxt = in_comment_r;
    in_sep_nxt     = in_sep_r;
    tok_len_nxt    = tok_len_r;
    tok_val_nxt    = tok_val_r;
    tok_bad_nxt    = tok_bad_r;
    saved_w_nxt    = saved_w_r;
    saved_h_nxt    = saved_h_r;
    res_push       = 1'b0;
    res            = '0;

    if (step) begin
      active    = (phase_r != PH_DONE);
      tok_phase = (phase_r == PH_MAGIC) || (phase_r == PH_WIDTH) ||
                  (phase_r == PH_HEIGHT) || (phase_r == PH_MAXVAL);
      if (active) begin
        if (in_comment_r) begin
          if (item.is_lf) begin
            in_comment_nxt = 1'b0;
          end
        end else if (item.is_sep) begin
          if (item.is_hash) begin
            in_comment_nxt = 1'b1;
          end
          if (tok_phase && !in_sep_r) begin
            // Close the current token.
            ok = !tok_bad_r;
            if (phase_r == PH_MAGIC && tok_len_r != LW'(2)) begin
              ok = 1'b0;
            end
            if (phase_r == PH_MAXVAL && tok_val_r[VALUE_W-1]) begin
              ok = 1'b0;
            end
            if (!ok) begin
              res_push = 1'b1;
              unique case (phase_r)
                PH_MAGIC:  res.status = ST_BAD_MAGIC;
                PH_WIDTH:  res.status = ST_BAD_WIDTH;
                PH_HEIGHT: res.status = ST_BAD_HEIGHT;
                default:   res.status = ST_BAD_MAXVAL;
              endcase
              phase_nxt = PH_DONE;
            end else begin
              if (phase_r == PH_WIDTH) begin
                saved_w_nxt = tok_val_r;
              end
              if (phase_r == PH_HEIGHT) begin
                saved_h_nxt = tok_val_r;
              end
              if (phase_r != PH_MAXVAL) begin
                tok_val_nxt = '0;
              end
              tok_len_nxt = '0;
              tok_bad_nxt = 1'b0;
              unique case (phase_r)
                PH_MAGIC:  phase_nxt = PH_WIDTH;
                PH_WIDTH:  phase_nxt = PH_HEIGHT;
                PH_HEIGHT: phase_nxt = PH_MAXVAL;
                default:   phase_nxt = PH_DATA;
              endcase
            end
          end
          in_sep_nxt = 1'b1;
        end else if (phase_r == PH_DATA) begin
          res_push              = 1'b1;
          res.status            = ST_OK;
          res.width             = saved_w_r;
          res.height            = saved_h_r;
          res.max_value         = tok_val_r[MAXV_W-1:0];
          res.first_data_byte   = item.data;
          phase_nxt             = PH_DONE;
        end else begin
          in_sep_nxt = 1'b0;
          if (tok_len_r >= LW'(MAX_TOKEN_CHARS)) begin
            tok_bad_nxt = 1'b1;
          end else begin
            if (phase_r == PH_MAGIC) begin
              if (tok_len_r >= LW'(2) ||
                  item.data != ((tok_len_r == '0) ? CH_P : CH_SIX)) begin
                tok_bad_nxt = 1'b1;
              end
            end else if (!item.is_digit) begin
              tok_bad_nxt = 1'b1;
            end else if (!tok_bad_r) begin
              if (mac[VALUE_W+3:VALUE_W] != '0) begin
                tok_bad_nxt = 1'b1;
              end else begin
                tok_val_nxt = mac[VALUE_W-1:0];
              end
            end
            tok_len_nxt = tok_len_r + 1'b1;
          end
        end
      end

      if (item.is_final) begin
        // End of file: report truncation if nothing was reported yet.
        if (!res_push && active) begin
          res_push   = 1'b1;
          res        = '0;
          res.status = ST_TRUNCATED;
        end
        phase_nxt      = PH_MAGIC;
        in_comment_nxt = 1'b0;
        in_sep_nxt     = 1'b0;
        tok_len_nxt    = '0;
        tok_val_nxt    = '0;
        tok_bad_nxt    = 1'b0;
        saved_w_nxt    = '0;
        saved_h_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC;
      in_comment_r <= 1'b0;
      in_sep_r     <= 1'b0;
      tok_len_r    <= '0;
      tok_val_r    <= '0;
      tok_bad_r    <= 1'b0;
      saved_w_r    <= '0;
      saved_h_r    <= '0;
    end else begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      in_sep_r     <= in_sep_nxt;
      tok_len_r    <= tok_len_nxt;
      tok_val_r    <= tok_val_nxt;
      tok_bad_r    <= tok_bad_nxt;
      saved_w_r    <= saved_w_nxt;
      saved_h_r    <= saved_h_nxt;
    end
  end

endmodule

FILE: design/ppmhp_header_parser_core.sv
// Top level of the binary PPM header parser: front end, queues and back end.
//
// Channel   Direction  Handshake          Payload
// in_*      input      in_push / in_full   in_data_byte, in_is_final
// out_*     output     out_pop / out_empty out_status, out_width, out_height,
//                                          out_max_value, out_first_data_byte
//
// The block takes one byte request per clock cycle, sustained while in_full is low.
// A result is written into the result queue when the back end takes the byte causing
// it from the byte queue, which registers every byte; the result queue reads out
// directly, so a result at its head is on the out_* ports right after the write.
// Reset (rst_n low, synchronous) empties both queues and returns the parser to
// the start of a file.
// When the result queue fills, the back end holds; the byte queue then fills
// and in_full rises, so no request is ever dropped.
module ppm_header_parser_core
  import ppmhp_pkg::*;
#(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_is_final,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [2:0]         out_status,
  output logic [VALUE_W-1:0] out_width,
  output logic [VALUE_W-1:0] out_height,
  output logic [MAXV_W-1:0]  out_max_value,
  output logic [7:0]         out_first_data_byte
);

  item_t   in_item;
  item_t   q_item;
  logic    q_empty;
  logic    q_pop;
  logic    res_full;
  logic    res_push;
  result_t res;
  result_t out_res;

  // Classify the byte on the way in; the class bits travel with it.
  ppmhp_front u_front (
    .data_byte (in_data_byte),
    .is_final  (in_is_final),
    .item      (in_item)
  );

  // Byte queue between the front and the back end.
  ppmhp_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .T     (item_t)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_item),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  // The parse itself: one queued byte per cycle while the result queue has room.
  ppmhp_back #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  // Result queue; it decouples the parser from the consumer's pop timing.
  ppmhp_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .T     (result_t)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_status          = out_res.status;
  assign out_width           = out_res.width;
  assign out_height          = out_res.height;
  assign out_max_value       = out_res.max_value;
  assign out_first_data_byte = out_res.first_data_byte;

endmodule

FILE: sim/ppm_header_parser_checker.sv
// Checker that predicts the parser's header reports and compares them with the result port.
module ppm_header_parser_checker
  import ppmhp_pkg::*;
#(
  parameter int MAX_CHARS = MAX_TOKEN_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_is_final,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [2:0]         out_status,
  input  logic [VALUE_W-1:0] out_width,
  input  logic [VALUE_W-1:0] out_height,
  input  logic [MAXV_W-1:0]  out_max_value,
  input  logic [7:0]         out_first_data_byte,
  output int                 fail_count,
  output int                 reports_left
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXVAL = 3'd3,
    PH_DATA   = 3'd4,
    PH_DONE   = 3'd5
  } parse_phase_t;

  localparam logic [31:0] VALUE_CEILING  = 32'h1FFFF;
  localparam logic [31:0] MAXVAL_CEILING = 32'd65536;

  parse_phase_t       phase;
  bit                 in_comment;
  bit                 between_tokens;
  int unsigned        tok_len;
  logic [VALUE_W-1:0] tok_val;
  bit                 tok_bad;
  logic [VALUE_W-1:0] saved_w;
  logic [VALUE_W-1:0] saved_h;
  result_t            reports_due[$];
  int                 mismatches = 0;

  function automatic status_t reject_code(input parse_phase_t ph);
    case (ph)
      PH_MAGIC:  return ST_BAD_MAGIC;
      PH_WIDTH:  return ST_BAD_WIDTH;
      PH_HEIGHT: return ST_BAD_HEIGHT;
      default:   return ST_BAD_MAXVAL;
    endcase
  endfunction

  task automatic restart_file();
    phase          = PH_MAGIC;
    in_comment     = 1'b0;
    between_tokens = 1'b0;
    tok_len        = 0;
    tok_val        = '0;
    tok_bad        = 1'b0;
    saved_w        = '0;
    saved_h        = '0;
  endtask

  task automatic close_token(output bit got, output result_t rep);
    bit ok;
    ok  = !tok_bad;
    got = 1'b0;
    rep = '0;
    if (phase == PH_MAGIC && tok_len != 2) ok = 1'b0;
    if (phase == PH_MAXVAL && tok_val >= MAXVAL_CEILING) ok = 1'b0;
    if (!ok) begin
      rep.status = reject_code(phase);
      phase      = PH_DONE;
      got        = 1'b1;
    end else begin
      if (phase == PH_WIDTH) saved_w = tok_val;
      else if (phase == PH_HEIGHT) saved_h = tok_val;
      // maxval stays in the token register until the first data byte shows up.
      if (phase != PH_MAXVAL) tok_val = '0;
      tok_len = 0;
      tok_bad = 1'b0;
      phase   = parse_phase_t'(phase + 3'd1);
    end
  endtask

  task automatic take_char(input logic [7:0] b);
    logic [31:0] acc;
    logic [7:0]  want;
    if (tok_len >= MAX_CHARS) begin
      tok_bad = 1'b1;
    end else begin
      if (phase == PH_MAGIC) begin
        want = (tok_len == 0) ? CH_P : CH_SIX;
        if (tok_len >= 2 || b != want) tok_bad = 1'b1;
      end else if (b < CH_ZERO || b > CH_NINE) begin
        tok_bad = 1'b1;
      end else if (!tok_bad) begin
        acc = 32'(tok_val) * 32'd10 + 32'(b - CH_ZERO);
        if (acc > VALUE_CEILING) tok_bad = 1'b1;
        else tok_val = acc[VALUE_W-1:0];
      end
      tok_len++;
    end
  endtask

  task automatic parse_header_byte(input logic [7:0] b, input logic fin,
                                   output bit got, output result_t rep);
    bit active;
    bit sep;
    got    = 1'b0;
    rep    = '0;
    active = (phase != PH_DONE);
    sep    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF) ||
             (b == CH_HASH);
    if (active) begin
      if (in_comment) begin
        if (b == CH_LF) in_comment = 1'b0;
      end else if (sep) begin
        if (b == CH_HASH) in_comment = 1'b1;
        if (phase < PH_DATA && !between_tokens) close_token(got, rep);
        between_tokens = 1'b1;
      end else if (phase == PH_DATA) begin
        rep.status          = ST_OK;
        rep.width           = saved_w;
        rep.height          = saved_h;
        rep.max_value       = tok_val[MAXV_W-1:0];
        rep.first_data_byte = b;
        phase               = PH_DONE;
        got                 = 1'b1;
      end else begin
        between_tokens = 1'b0;
        take_char(b);
      end
    end
    if (fin) begin
      if (!got && active) begin
        rep        = '0;
        rep.status = ST_TRUNCATED;
        got        = 1'b1;
      end
      restart_file();
    end
  endtask

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 100) $display("%0t checker: %s", $time, what);
  endtask

  always @(posedge clk) begin
    bit      got;
    result_t want;
    result_t seen;
    if (!rst_n) begin
      restart_file();
      reports_due.delete();
    end else begin
      if (in_push && !in_full) begin
        parse_header_byte(in_data_byte, in_is_final, got, want);
        if (got) reports_due.push_back(want);
      end
      if (out_pop && !out_empty) begin
        seen.status          = status_t'(out_status);
        seen.width           = out_width;
        seen.height          = out_height;
        seen.max_value       = out_max_value;
        seen.first_data_byte = out_first_data_byte;
        if (reports_due.size() == 0) begin
          report($sformatf("unexpected report, status %0d", out_status));
        end else begin
          want = reports_due.pop_front();
          if (seen.status !== want.status)
            report($sformatf("status %0d, predicted %0d", seen.status, want.status));
          if (seen.width !== want.width)
            report($sformatf("width %0d, predicted %0d", seen.width, want.width));
          if (seen.height !== want.height)
            report($sformatf("height %0d, predicted %0d", seen.height, want.height));
          if (seen.max_value !== want.max_value)
            report($sformatf("maxval %0d, predicted %0d", seen.max_value, want.max_value));
          if (seen.first_data_byte !== want.first_data_byte)
            report($sformatf("first data byte %0h, predicted %0h",
                             seen.first_data_byte, want.first_data_byte));
        end
      end
    end
    fail_count   <= mismatches;
    reports_left <= reports_due.size();
  end

endmodule

FILE: sim/ppm_header_parser_core_tb.sv
// Testbench top that feeds PPM files byte by byte into the header parser and gives the verdict.
module ppm_header_parser_core_tb
  import ppmhp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. The byte target sets when random files stop; the calm point starts the
  // final stretch without any idling; the hold point triggers the long receiver stall.
  localparam int ITEM_TARGET      = 1900;
  localparam int CALM_AFTER       = 1650;
  localparam int HOLD_AT          = 600;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int BURST_FILES      = 40;
  localparam int DRAIN_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_data_byte = 8'd0;
  logic               in_is_final = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [2:0]         out_status;
  logic [VALUE_W-1:0] out_width;
  logic [VALUE_W-1:0] out_height;
  logic [MAXV_W-1:0]  out_max_value;
  logic [7:0]         out_first_data_byte;

  int         fail_count;
  int         reports_left;
  int         bytes_sent = 0;
  int         cycles = 0;
  bit         calm = 1'b0;
  bit         long_hold = 1'b0;
  logic [7:0] file_bytes[$];

  ppm_header_parser_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_data_byte        (in_data_byte),
    .in_is_final         (in_is_final),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_status          (out_status),
    .out_width           (out_width),
    .out_height          (out_height),
    .out_max_value       (out_max_value),
    .out_first_data_byte (out_first_data_byte)
  );

  ppm_header_parser_checker #(
    .MAX_CHARS (MAX_TOKEN_CHARS_DEF)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_data_byte        (in_data_byte),
    .in_is_final         (in_is_final),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_status          (out_status),
    .out_width           (out_width),
    .out_height          (out_height),
    .out_max_value       (out_max_value),
    .out_first_data_byte (out_first_data_byte),
    .fail_count          (fail_count),
    .reports_left        (reports_left)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: if the run has not ended by the limit, something hung.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side. Pop is mostly high, with random stall bursts until the calm
  // stretch. Once the main process raises long_hold, pop stays low for a long,
  // counted stretch so that both internal queues fill and in_full rises.
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_pop <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Separator test used only to keep generated data bytes and bad characters
  // from accidentally ending a token.
  function automatic bit is_gap_char(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF) ||
           (b == CH_HASH);
  endfunction

  // A random byte that does not separate tokens; digits are excluded on request.
  function automatic logic [7:0] plain_char(input bit digits_ok);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (is_gap_char(b) || (!digits_ok && b >= CH_ZERO && b <= CH_NINE));
    return b;
  endfunction

  // Offers one byte request and waits until the parser takes it. A random idle
  // burst may come first; push is only lowered in a step where it is not raised.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_is_final  <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the assembled file, marking its last byte as the end of the file.
  task automatic send_file();
    foreach (file_bytes[i]) push_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endtask

  // One to three separators, any of which may be a comment running to LF.
  task automatic append_gap();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 5))
        0: file_bytes.push_back(CH_SPACE);
        1: file_bytes.push_back(CH_TAB);
        2: file_bytes.push_back(CH_CR);
        3: file_bytes.push_back(CH_LF);
        4: begin
          file_bytes.push_back(CH_HASH);
          repeat ($urandom_range(0, 6)) file_bytes.push_back(plain_char(1'b1));
          file_bytes.push_back(CH_LF);
        end
        default: file_bytes.push_back(CH_SPACE);
      endcase
    end
  endtask

  // A magic token that must be rejected, including one behind a leading separator.
  task automatic append_bad_magic();
    case ($urandom_range(0, 5))
      0: append_text(" P6");
      1: append_text("P5");
      2: append_text("P");
      3: append_text("P66");
      4: append_text("p6");
      default: begin
        file_bytes.push_back(plain_char(1'b1));
        file_bytes.push_back(plain_char(1'b1));
      end
    endcase
  endtask

  // A numeric token the parser must accept; idx 0 is width, 1 height, 2 maxval.
  function automatic string clean_number(input int idx);
    int unsigned top;
    top = (idx == 2) ? 65535 : 99999;
    case ($urandom_range(0, 9))
      5, 6:    return $sformatf("%0d", $urandom_range(0, top));
      7:       return {"0", $sformatf("%0d", $urandom_range(0, 999))};
      8:       return ($urandom_range(0, 1) == 0) ? $sformatf("%0d", top) : "0";
      9:       return "00000";
      default: return $sformatf("%0d", $urandom_range(0, 99));
    endcase
  endfunction

  // A numeric token the parser must reject: too long, out of range or not a number.
  function automatic string broken_number(input int idx);
    string s;
    case ($urandom_range(0, 2))
      0: s = $sformatf("%0d", $urandom_range(100000, 9999999));
      1: s = (idx == 2) ? $sformatf("%0d", $urandom_range(65536, 99999))
                        : $sformatf("%0d", $urandom_range(100000, 999999));
      default: begin
        s = clean_number(idx);
        s[$urandom_range(0, s.len() - 1)] = plain_char(1'b0);
      end
    endcase
    return s;
  endfunction

  // Builds and sends one random file. Most are well formed headers with random
  // content; the rest carry one fault, are cut short, or are plain noise.
  task automatic send_random_file();
    int kind;
    int bad_at;
    int cut;
    file_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // Fault position: none, the magic token, one of the numbers, or truncation.
      bad_at = (kind < 70) ? -1 : $urandom_range(0, 4);
      if (bad_at == 0) append_bad_magic();
      else append_text("P6");
      for (int t = 0; t < 3; t++) begin
        append_gap();
        append_text((bad_at == t + 1) ? broken_number(t) : clean_number(t));
      end
      append_gap();
      file_bytes.push_back(plain_char(1'b1));
      // Bytes after the report belong to the pixel data and must be ignored.
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
      if (bad_at == 4) begin
        cut = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
    end
    send_file();
  endtask

  initial begin
    bit held;
    held = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed files. A lone space ends an empty magic token, so it is a bad
    // magic report rather than truncation.
    file_bytes.delete();
    append_text(" ");
    send_file();
    // Comment after the magic, zero width and height, the largest maxval,
    // CR as the last separator, a zero data byte and an all-ones byte after it.
    file_bytes.delete();
    append_text("P6#\n0 0 65535\r");
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    send_file();
    // The file ends in the middle of the magic token.
    file_bytes.delete();
    append_text("P");
    send_file();
    // Wrong magic digit.
    file_bytes.delete();
    append_text("P7 ");
    send_file();

    while (bytes_sent < ITEM_TARGET) begin
      if (!held && bytes_sent >= HOLD_AT) begin
        // One-byte files each give a report, so with the receiver held off the
        // result queue fills quickly and the byte queue backs up behind it.
        held      = 1'b1;
        long_hold = 1'b1;
        repeat (BURST_FILES) begin
          file_bytes.delete();
          file_bytes.push_back(8'($urandom_range(0, 255)));
          send_file();
        end
      end
      calm = (bytes_sent >= CALM_AFTER);
      send_random_file();
    end
    in_push <= 1'b0;

    // Wait for every predicted report, then keep the clock running for stray ones.
    do @(posedge clk); while (reports_left != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: ppm_header_parser_core.f
design/ppmhp_pkg.sv
design/ppmhp_fifo.sv
design/ppmhp_front.sv
design/ppmhp_back.sv
design/ppmhp_header_parser_core.sv
sim/ppm_header_parser_checker.sv
sim/ppm_header_parser_core_tb.sv
